// ----- hw/rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, sampled on clock and held off in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GBTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define GBTS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/gbts_pkg.sv -----
// ============================================================================
// Grid bottleneck threshold search package
// Shared constants, register indexes and controller/datapath interface types.
// ============================================================================
package gbts_pkg;

   // Default sizing of the grid and height range.
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLS    = 64;
   localparam int DEF_HEIGHT_BITS = 16;

   // Fixed field widths of the ports.
   localparam int HEIGHT_FIELD_W = 16;
   localparam int MIN_STEP_W     = 17;
   localparam int RSP_TDATA_W    = 24;
   localparam int CFG_REG_W      = 7;
   localparam int CSR_IDX_W      = 2;
   localparam int CLAMP_W        = 10;

   // Configuration register indexes and reset value.
   localparam logic [CSR_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
   localparam logic [CFG_REG_W-1:0] CFG_RESET_VAL = 7'd64;

   // Neighbor directions of the flood fill.
   typedef logic [1:0] dir_type;
   localparam dir_type DIR_DOWN  = 2'd0;
   localparam dir_type DIR_RIGHT = 2'd1;
   localparam dir_type DIR_UP    = 2'd2;
   localparam dir_type DIR_LEFT  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic srch_init;
      logic div_step;
      logic trial_init;
      logic clr_step;
      logic seed;
      logic pop;
      logic pop_load;
      logic hgt_load;
      logic nadr;
      logic neval;
      logic chk_rd;
      logic chk_ev;
      logic trial_done;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_bad;
      logic div_busy;
      logic k_end;
      logic sp_zero;
      logic nb_ok;
      logic dir_last;
      logic search_over;
      logic rsp_free;
   } status_type;

endpackage

// ----- hw/rtl/gbts_ram.sv -----
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module gbts_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gbts_ctrl.sv -----
// ============================================================================
// Search controller
// Sequences cell loading, the binary search over trials and each flood fill.
// ============================================================================
`include "assert_macros.svh"

module gbts_ctrl import gbts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_INIT  = 15'b000000000000010,
      S_DIV   = 15'b000000000000100,
      S_TINIT = 15'b000000000001000,
      S_CLR   = 15'b000000000010000,
      S_SEED  = 15'b000000000100000,
      S_POP   = 15'b000000001000000,
      S_POPD  = 15'b000000010000000,
      S_HGT   = 15'b000000100000000,
      S_NADR  = 15'b000001000000000,
      S_NEVAL = 15'b000010000000000,
      S_CHKRD = 15'b000100000000000,
      S_CHKEV = 15'b001000000000000,
      S_TDONE = 15'b010000000000000,
      S_FIN   = 15'b100000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.srch_init = 1'b1;
            state_in      = status.start_bad ? S_FIN : S_DIV;
         end
         S_DIV: begin
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               state_in = S_TINIT;
            end
         end
         S_TINIT: begin
            if (status.search_over) begin
               state_in = S_FIN;
            end else begin
               cmd.trial_init = 1'b1;
               state_in       = S_CLR;
            end
         end
         S_CLR: begin
            if (status.k_end) begin
               state_in = S_SEED;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_SEED: begin
            cmd.seed = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            if (status.sp_zero) begin
               state_in = S_CHKRD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_POPD;
            end
         end
         S_POPD: begin
            cmd.pop_load = 1'b1;
            state_in     = S_HGT;
         end
         S_HGT: begin
            cmd.hgt_load = 1'b1;
            state_in     = S_NADR;
         end
         S_NADR: begin
            cmd.nadr = 1'b1;
            if (status.nb_ok) begin
               state_in = S_NEVAL;
            end else if (status.dir_last) begin
               state_in = S_POP;
            end
         end
         S_NEVAL: begin
            cmd.neval = 1'b1;
            state_in  = status.dir_last ? S_POP : S_NADR;
         end
         S_CHKRD: begin
            if (status.k_end) begin
               state_in = S_TDONE;
            end else begin
               cmd.chk_rd = 1'b1;
               state_in   = S_CHKEV;
            end
         end
         S_CHKEV: begin
            cmd.chk_ev = 1'b1;
            state_in   = S_CHKRD;
         end
         S_TDONE: begin
            cmd.trial_done = 1'b1;
            state_in       = S_TINIT;
         end
         S_FIN: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The result register is only loaded once the previous result has left.
   `GBTS_ASSERT(a_fin_free, !cmd.finish || status.rsp_free, "result overwritten")
   // A new cell is never taken while a search is running.
   `GBTS_ASSERT(a_load_idle, !cmd.load || (state_ff == S_IDLE), "cell taken during search")

endmodule

// ----- hw/rtl/gbts_dp.sv -----
// ============================================================================
// Search datapath
// Grid memories, flood fill stack, binary search bounds and the result register.
// ============================================================================
`include "assert_macros.svh"

module gbts_dp import gbts_pkg::*; #(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [CFG_REG_W-1:0]      row_cnt,
   input  logic [CFG_REG_W-1:0]      col_cnt,
   input  logic [HEIGHT_FIELD_W-1:0] req_height,
   input  logic                      req_wp,
   input  logic                      rsp_tready,
   output logic                      rsp_valid,
   output logic [MIN_STEP_W-1:0]     rsp_min_step
);

   localparam int H     = HEIGHT_BITS;
   localparam int LW    = HEIGHT_BITS + 2;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW    = $clog2(CELLS + 1);
   localparam int RB    = $clog2(MAX_ROWS + 1);
   localparam int CB    = $clog2(MAX_COLS + 1);
   localparam int EW    = RB + CB + AW;

   // Grid geometry from the configuration registers, zero taken as one, clamped to the maximum.
   logic [CLAMP_W-1:0] r_wide, c_wide;
   logic [RB-1:0]      rows;
   logic [CB-1:0]      cols;
   logic [SW-1:0]      size;

   assign r_wide = CLAMP_W'(row_cnt);
   assign c_wide = CLAMP_W'(col_cnt);
   assign rows = (r_wide == '0) ? RB'(1) :
                 (r_wide > CLAMP_W'(MAX_ROWS)) ? RB'(MAX_ROWS) : RB'(r_wide);
   assign cols = (c_wide == '0) ? CB'(1) :
                 (c_wide > CLAMP_W'(MAX_COLS)) ? CB'(MAX_COLS) : CB'(c_wide);
   assign size = SW'(rows) * SW'(cols);

   // Registers.
   logic [SW-1:0]         cell_idx_ff, cell_idx_in;
   logic [H-1:0]          min_ff, min_in, max_ff, max_in;
   logic                  first_valid_ff, first_valid_in;
   logic [AW-1:0]         fw_ff, fw_in;
   logic [AW-1:0]         rem_ff, rem_in;
   logic [RB-1:0]         drow_ff, drow_in;
   logic [LW-1:0]         lo_ff, lo_in, hi_ff, hi_in, ans_ff, ans_in, limit_ff, limit_in;
   logic                  brk_ff, brk_in, fail_ff, fail_in;
   logic [SW-1:0]         k_ff, k_in, sp_ff, sp_in;
   logic [RB-1:0]         cr_ff, cr_in, nr_ff, nr_in;
   logic [CB-1:0]         cq_ff, cq_in, nq_ff, nq_in;
   logic [AW-1:0]         cc_ff, cc_in, nc_ff, nc_in;
   logic [H-1:0]          a_ff, a_in;
   dir_type               dir_ff, dir_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MIN_STEP_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic          hgt_we, wp_we, vis_we, stk_we, vis_wdata;
   logic [AW-1:0] hgt_raddr, vis_waddr, vis_raddr, stk_waddr, stk_raddr;
   logic [H-1:0]  hgt_rdata, h_in;
   logic          wp_rdata, vis_rdata;
   logic [EW-1:0] stk_wdata, stk_rdata;

   // Neighbor of the current cell in the current direction.
   logic          nb_ok;
   logic [RB-1:0] nb_r;
   logic [CB-1:0] nb_q;
   logic [AW-1:0] nb_c;

   always_comb begin
      nb_ok = 1'b0;
      nb_r  = cr_ff;
      nb_q  = cq_ff;
      nb_c  = cc_ff;
      case (dir_ff)
         DIR_DOWN: begin
            nb_ok = (cr_ff + RB'(1)) < rows;
            nb_r  = cr_ff + RB'(1);
            nb_c  = AW'(SW'(cc_ff) + SW'(cols));
         end
         DIR_RIGHT: begin
            nb_ok = (cq_ff + CB'(1)) < cols;
            nb_q  = cq_ff + CB'(1);
            nb_c  = cc_ff + AW'(1);
         end
         DIR_UP: begin
            nb_ok = (cr_ff != '0);
            nb_r  = cr_ff - RB'(1);
            nb_c  = AW'(SW'(cc_ff) - SW'(cols));
         end
         DIR_LEFT: begin
            nb_ok = (cq_ff != '0);
            nb_q  = cq_ff - CB'(1);
            nb_c  = cc_ff - AW'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   // Search helpers.
   logic          load_ok, push_ok, start_bad;
   logic [LW:0]   mid_sum;
   logic [LW-1:0] mid;
   logic [H-1:0]  diff;

   assign h_in      = H'(req_height);
   assign load_ok   = cmd.load && (cell_idx_ff < size);
   assign start_bad = !first_valid_ff || (SW'(fw_ff) >= size);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[LW:1];
   assign diff      = (a_ff > hgt_rdata) ? (a_ff - hgt_rdata) : (hgt_rdata - a_ff);
   assign push_ok   = cmd.neval && !vis_rdata && (LW'(diff) <= limit_ff);

   // Memory addressing.
   assign hgt_we    = load_ok;
   assign wp_we     = load_ok;
   assign hgt_raddr = cmd.pop_load ? stk_rdata[AW-1:0] : nb_c;
   assign vis_raddr = cmd.chk_rd ? k_ff[AW-1:0] : nb_c;
   assign vis_we    = cmd.clr_step || cmd.seed || push_ok;
   assign vis_waddr = cmd.clr_step ? k_ff[AW-1:0] : (cmd.seed ? fw_ff : nc_ff);
   assign vis_wdata = !cmd.clr_step;
   assign stk_we    = cmd.seed || push_ok;
   assign stk_waddr = cmd.seed ? '0 : sp_ff[AW-1:0];
   assign stk_wdata = cmd.seed ? {drow_ff, CB'(rem_ff), fw_ff} : {nr_ff, nq_ff, nc_ff};
   assign stk_raddr = AW'(sp_ff - SW'(1));

   // Next values of the registers.
   always_comb begin
      cell_idx_in    = cell_idx_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      first_valid_in = first_valid_ff;
      fw_in          = fw_ff;
      rem_in         = rem_ff;
      drow_in        = drow_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      ans_in         = ans_ff;
      limit_in       = limit_ff;
      brk_in         = brk_ff;
      fail_in        = fail_ff;
      k_in           = k_ff;
      sp_in          = sp_ff;
      cr_in          = cr_ff;
      cq_in          = cq_ff;
      cc_in          = cc_ff;
      nr_in          = nr_ff;
      nq_in          = nq_ff;
      nc_in          = nc_ff;
      a_in           = a_ff;
      dir_in         = dir_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      // Store a cell and track the height range and the first waypoint.
      if (load_ok) begin
         cell_idx_in = cell_idx_ff + SW'(1);
         if (h_in < min_ff) begin
            min_in = h_in;
         end
         if (h_in > max_ff) begin
            max_in = h_in;
         end
         if (req_wp && !first_valid_ff) begin
            first_valid_in = 1'b1;
            fw_in          = cell_idx_ff[AW-1:0];
         end
      end

      // Set up the search range and the start-row search.
      if (cmd.srch_init) begin
         lo_in   = '0;
         hi_in   = (min_ff <= max_ff) ? (LW'(max_ff) - LW'(min_ff) + LW'(1)) : '0;
         ans_in  = start_bad ? '0 :
                   ((min_ff <= max_ff) ? (LW'(max_ff) - LW'(min_ff) + LW'(1)) : '0);
         brk_in  = 1'b0;
         rem_in  = fw_ff;
         drow_in = '0;
      end

      // Row of the start cell by repeated subtraction of the row length.
      if (cmd.div_step) begin
         rem_in  = rem_ff - AW'(cols);
         drow_in = drow_ff + RB'(1);
      end

      if (cmd.trial_init) begin
         limit_in = mid;
         k_in     = '0;
         fail_in  = 1'b0;
      end

      if (cmd.clr_step || cmd.chk_ev) begin
         k_in = k_ff + SW'(1);
      end

      if (cmd.seed) begin
         sp_in = SW'(1);
         k_in  = '0;
      end

      if (cmd.pop) begin
         sp_in = sp_ff - SW'(1);
      end

      if (cmd.pop_load) begin
         {cr_in, cq_in, cc_in} = stk_rdata;
      end

      if (cmd.hgt_load) begin
         a_in   = hgt_rdata;
         dir_in = DIR_DOWN;
      end

      // Latch the neighbor; skip it at once when it is off the grid.
      if (cmd.nadr) begin
         nr_in = nb_r;
         nq_in = nb_q;
         nc_in = nb_c;
         if (!nb_ok) begin
            dir_in = dir_ff + 2'd1;
         end
      end

      if (cmd.neval) begin
         dir_in = dir_ff + 2'd1;
         if (push_ok) begin
            sp_in = sp_ff + SW'(1);
         end
      end

      if (cmd.chk_ev && wp_rdata && !vis_rdata) begin
         fail_in = 1'b1;
      end

      // Narrow the search range after a trial.
      if (cmd.trial_done) begin
         if (!fail_ff) begin
            ans_in = limit_ff;
            if (limit_ff == '0) begin
               brk_in = 1'b1;
            end else begin
               hi_in = limit_ff - LW'(1);
            end
         end else begin
            lo_in = limit_ff + LW'(1);
         end
      end

      // Hand out the result and start a fresh grid.
      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_data_in    = MIN_STEP_W'(ans_ff);
         cell_idx_in    = '0;
         min_in         = '1;
         max_in         = '0;
         first_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_idx_ff    <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         first_valid_ff <= 1'b0;
         lo_ff          <= '0;
         hi_ff          <= '0;
         brk_ff         <= 1'b0;
         fail_ff        <= 1'b0;
         k_ff           <= '0;
         sp_ff          <= '0;
         dir_ff         <= DIR_DOWN;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cell_idx_ff    <= cell_idx_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         first_valid_ff <= first_valid_in;
         lo_ff          <= lo_in;
         hi_ff          <= hi_in;
         brk_ff         <= brk_in;
         fail_ff        <= fail_in;
         k_ff           <= k_in;
         sp_ff          <= sp_in;
         dir_ff         <= dir_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fw_ff       <= fw_in;
      rem_ff      <= rem_in;
      drow_ff     <= drow_in;
      ans_ff      <= ans_in;
      limit_ff    <= limit_in;
      cr_ff       <= cr_in;
      cq_ff       <= cq_in;
      cc_ff       <= cc_in;
      nr_ff       <= nr_in;
      nq_ff       <= nq_in;
      nc_ff       <= nc_in;
      a_ff        <= a_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell memories, visited marks and the fill stack.
   gbts_ram #(.WIDTH(H), .DEPTH(CELLS)) u_height (
      .clock(clock), .wr_en(hgt_we), .wr_addr(cell_idx_ff[AW-1:0]), .wr_data(h_in),
      .rd_addr(hgt_raddr), .rd_data(hgt_rdata)
   );

   gbts_ram #(.WIDTH(1), .DEPTH(CELLS)) u_waypoint (
      .clock(clock), .wr_en(wp_we), .wr_addr(cell_idx_ff[AW-1:0]), .wr_data(req_wp),
      .rd_addr(k_ff[AW-1:0]), .rd_data(wp_rdata)
   );

   gbts_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(vis_raddr), .rd_data(vis_rdata)
   );

   gbts_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   // Status to the controller.
   assign status.start_bad   = start_bad;
   assign status.div_busy    = SW'(rem_ff) >= SW'(cols);
   assign status.k_end       = (k_ff == size);
   assign status.sp_zero     = (sp_ff == '0);
   assign status.nb_ok       = nb_ok;
   assign status.dir_last    = (dir_ff == DIR_LEFT);
   assign status.search_over = brk_ff || (lo_ff > hi_ff);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_step = rsp_data_ff;

   // Every cell is pushed at most once, so the stack never overruns.
   `GBTS_ASSERT(a_sp_bound, sp_ff <= SW'(CELLS), "fill stack overrun")
   // Binary search bounds never cross by more than one.
   `GBTS_ASSERT(a_bounds, ({1'b0, lo_ff} <= ({1'b0, hi_ff} + 1'b1)), "search bounds crossed")
   // After a result is posted the grid starts over.
   `GBTS_ASSERT_NEXT(a_restart, cmd.finish, rsp_valid_ff && (cell_idx_ff == '0) && !first_valid_ff,
                     "grid not restarted")

endmodule

// ----- hw/rtl/grid_bottleneck_threshold_search.sv -----
// ============================================================================
// Grid bottleneck threshold search
// Top level: configuration registers, controller and datapath.
// ============================================================================
// Cells arrive in raster order, one per cycle while the block is idle; those
// within the rows*cols in use are written straight into the grid memory, the
// rest are dropped. The transaction with tlast set starts the search and its
// single result leaves on the rsp channel as the smallest height-difference
// limit that links every waypoint to the first one (0 with no waypoint). The
// search holds off new cells. It first finds the start row by repeated
// subtraction, then runs about log2(max-min+2)+1 flood-fill trials. Each trial
// clears the visited memory, walks the fill stack (one memory read at a time)
// and checks every waypoint.

module grid_bottleneck_threshold_search import gbts_pkg::*; #(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // Cell input.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [HEIGHT_FIELD_W-1:0] req_tdata,   // [15:0] height
   input  logic                      req_tuser,   // [0] is_waypoint
   input  logic                      req_tlast,   // last_cell
   // Result output.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_W-1:0]    rsp_tdata,   // [16:0] min_step_limit
   // Configuration writes.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_REG_W-1:0]      csr_data
);

   logic [CFG_REG_W-1:0]  row_cnt_ff, row_cnt_in, col_cnt_ff, col_cnt_in;
   logic [MIN_STEP_W-1:0] min_step;
   cmd_type               cmd;
   status_type            status;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_ROW_COUNT: row_cnt_in = csr_data;
            CFG_COL_COUNT: col_cnt_in = csr_data;
            default: begin
               row_cnt_in = row_cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= CFG_RESET_VAL;
         col_cnt_ff <= CFG_RESET_VAL;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
      end
   end

   gbts_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tlast(req_tlast), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   gbts_dp #(
      .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .row_cnt(row_cnt_ff), .col_cnt(col_cnt_ff),
      .req_height(req_tdata), .req_wp(req_tuser),
      .rsp_tready(rsp_tready), .rsp_valid(rsp_tvalid), .rsp_min_step(min_step)
   );

   assign rsp_tdata = RSP_TDATA_W'(min_step);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Testbench for grid_bottleneck_threshold_search
// Loads small height grids cell by cell and checks each step limit that the
// block reports against a flood-fill search predicted inside the testbench.
// ============================================================================
module tb;
   import gbts_pkg::*;

   localparam int GRID_MAX = DEF_MAX_ROWS * DEF_MAX_COLS;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [HEIGHT_FIELD_W-1:0] req_tdata = '0;   // [15:0] height
   logic                      req_tuser = 1'b0; // [0] is_waypoint
   logic                      req_tlast = 1'b0; // last_cell
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;        // [16:0] min_step_limit
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CFG_REG_W-1:0]      csr_data = '0;

   grid_bottleneck_threshold_search uut (.*);

   always #5 clock = ~clock;

   // Predictor state: a private copy of the grid, the search range and the registers.
   logic [15:0]        grid_height [GRID_MAX];
   bit                 grid_wp [GRID_MAX];
   bit                 seen [GRID_MAX];
   int unsigned        fill_stk [GRID_MAX];
   bit                 start_ok;
   int unsigned        start_cell;
   int unsigned        low_h, high_h, load_idx;
   logic [CFG_REG_W-1:0] rows_reg = CFG_RESET_VAL, cols_reg = CFG_RESET_VAL;

   logic [MIN_STEP_W-1:0] limit_q [$];
   int errors = 0;
   int items_sent = 0;
   int burst_left = 0;
   int hold_cycles = 0;
   bit hold_req = 1'b0;

   function automatic int unsigned clamp_dim(logic [CFG_REG_W-1:0] v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic void new_grid();
      start_ok = 1'b0;
      start_cell = 0;
      low_h = 16'hFFFF;
      high_h = 0;
      load_idx = 0;
   endfunction

   // Flood fill from the start cell; true when every waypoint is reached.
   function automatic bit fill_reaches_all(int unsigned start, int rows, int cols,
                                           int unsigned lim);
      int sp, r, q, nr, nq, d, c, nc;
      int unsigned a, b, diff;
      for (int k = 0; k < GRID_MAX; k++) seen[k] = 1'b0;
      sp = 0;
      seen[start] = 1'b1;
      fill_stk[sp++] = start;
      while (sp > 0) begin
         c = fill_stk[--sp];
         r = c / cols;
         q = c % cols;
         for (d = 0; d < 4; d++) begin
            nr = r + ((d == DIR_DOWN) ? 1 : (d == DIR_UP) ? -1 : 0);
            nq = q + ((d == DIR_RIGHT) ? 1 : (d == DIR_LEFT) ? -1 : 0);
            if (nr < 0 || nq < 0 || nr >= rows || nq >= cols) continue;
            nc = nr * cols + nq;
            if (seen[nc]) continue;
            a = grid_height[c];
            b = grid_height[nc];
            diff = (a > b) ? a - b : b - a;
            if (diff > lim) continue;
            seen[nc] = 1'b1;
            if (sp < GRID_MAX) fill_stk[sp++] = nc;
         end
      end
      for (int k = 0; k < rows * cols; k++)
         if (grid_wp[k] && !seen[k]) return 1'b0;
      return 1'b1;
   endfunction

   // Binary search for the smallest limit that links all waypoints.
   function automatic int unsigned bottleneck_limit();
      int rows, cols;
      int unsigned lo, hi, ans, mid;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      if (!start_ok || start_cell >= rows * cols) return 0;
      hi = (low_h <= high_h) ? high_h - low_h + 1 : 0;
      ans = hi;
      lo = 0;
      while (lo <= hi) begin
         mid = (lo + hi) >> 1;
         if (fill_reaches_all(start_cell, rows, cols, mid)) begin
            ans = mid;
            if (mid == 0) break;
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return ans;
   endfunction

   // Update the grid copy with one accepted cell.
   function automatic void predict_cell(logic [15:0] h, bit wp, bit last);
      if (load_idx < clamp_dim(rows_reg) * clamp_dim(cols_reg)) begin
         grid_height[load_idx] = h;
         grid_wp[load_idx] = wp;
         if (h < low_h) low_h = h;
         if (h > high_h) high_h = h;
         if (wp && !start_ok) begin
            start_ok = 1'b1;
            start_cell = load_idx;
         end
         load_idx++;
      end
      if (last) begin
         limit_q.push_back(MIN_STEP_W'(bottleneck_limit()));
         new_grid();
      end
   endfunction

   // Offer one cell; the sender works in bursts separated by random gaps.
   task automatic send_cell(logic [15:0] h, bit wp, bit last);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = h;
      req_tuser = wp;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      predict_cell(h, wp, last);
      items_sent++;
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Wait until every predicted result has arrived, then let the block settle.
   task automatic drain();
      idle_input();
      while (limit_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_REG_W-1:0] val);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CFG_ROW_COUNT) rows_reg = val;
      else if (idx == CFG_COL_COUNT) cols_reg = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_dims(logic [CFG_REG_W-1:0] r, logic [CFG_REG_W-1:0] c);
      write_reg(CFG_ROW_COUNT, r);
      write_reg(CFG_COL_COUNT, c);
   endtask

   // Send a grid of n cells with last on the final one; heights follow a style.
   task automatic send_grid(int n, int style, int wp_pct);
      logic [15:0] base, h;
      base = 16'($urandom);
      for (int k = 0; k < n; k++) begin
         case (style)
            0: h = 16'($urandom);
            1: h = 16'(base + $urandom_range(0, 40));
            2: h = 16'($urandom_range(0, 3) * 16'h5555);
            default: h = base;
         endcase
         send_cell(h, $urandom_range(1, 100) <= wp_pct, k == n - 1);
      end
   endtask

   // Fill every cell index used later, so no short grid reads unwritten cells.
   task automatic test_preload();
      set_dims(7'd8, 7'd8);
      send_grid(64, 0, 20);
   endtask

   task automatic test_directed();
      // Clamped registers: zero means one row and one column.
      set_dims(7'd0, 7'd0);
      send_cell(16'hFFFF, 1'b1, 1'b1);
      // Height extremes in the corners of a 2x2 grid.
      set_dims(7'd2, 7'd2);
      send_cell(16'h0000, 1'b1, 1'b0);
      send_cell(16'hFFFF, 1'b0, 1'b0);
      send_cell(16'hFFFF, 1'b0, 1'b0);
      send_cell(16'h0000, 1'b1, 1'b1);
      // No waypoint at all.
      send_cell(16'h1234, 1'b0, 1'b0);
      send_cell(16'h0001, 1'b0, 1'b0);
      send_cell(16'hFFFE, 1'b0, 1'b0);
      send_cell(16'h8000, 1'b0, 1'b1);
      // Excess cells past the grid are dropped.
      for (int k = 0; k < 7; k++) send_cell(16'($urandom), 1'b1, k == 6);
      // Short grid: the search covers cells from the previous load.
      set_dims(7'd4, 7'd4);
      send_grid(5, 0, 50);
      // One-wide strips at the register extremes, including a value above range.
      set_dims(7'd127, 7'd1);
      send_grid(64, 1, 10);
      set_dims(7'd1, 7'd64);
      send_grid(64, 2, 10);
      set_dims(7'd64, 7'd1);
      send_grid(64, 3, 10);
      // Indexes beyond the two registers are ignored.
      write_reg(2'd2, 7'd3);
      write_reg(2'd3, 7'd5);
      send_grid(3, 0, 60);
   endtask

   task automatic test_random();
      int n, size, kind;
      while (items_sent < 1500) begin
         if ($urandom_range(0, 2) == 0) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) set_dims(7'd0, CFG_REG_W'($urandom_range(1, 8)));
            else if (kind == 1) set_dims(CFG_REG_W'($urandom_range(65, 127)), 7'd1);
            else set_dims(CFG_REG_W'($urandom_range(1, 8)),
                          CFG_REG_W'($urandom_range(1, 8)));
         end
         size = clamp_dim(rows_reg) * clamp_dim(cols_reg);
         kind = $urandom_range(0, 9);
         if (kind == 0) n = $urandom_range(1, size);
         else if (kind == 1) n = size + $urandom_range(1, 6);
         else n = size;
         send_grid(n, $urandom_range(0, 3), $urandom_range(0, 3) == 0 ? 0 :
                   $urandom_range(5, 60));
      end
   endtask

   // Hold the result side off while cells keep coming, then resume.
   task automatic test_backpressure();
      set_dims(7'd3, 7'd3);
      hold_req = 1'b1;
      send_grid(9, 0, 40);
      send_grid(9, 1, 40);
      send_grid(9, 2, 40);
      drain();
   endtask

   // Result side: long hold when asked, otherwise a changing stall pattern.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req <= 1'b0;
         hold_cycles <= 3000;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ((items_sent / 64) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Compare each result transaction with the oldest predicted limit.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (limit_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %0d", rsp_tdata);
         end else begin
            if (rsp_tdata !== RSP_TDATA_W'(limit_q[0])) begin
               errors++;
               if (errors <= 10)
                  $display("min_step_limit mismatch: expected %0d, got %0d",
                           limit_q[0], rsp_tdata);
            end
            void'(limit_q.pop_front());
         end
      end
   end

   initial begin
      new_grid();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_preload();
      test_directed();
      test_backpressure();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && limit_q.size() == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   initial begin
      #1000ms;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_ram.sv
hw/rtl/gbts_ctrl.sv
hw/rtl/gbts_dp.sv
hw/rtl/grid_bottleneck_threshold_search.sv
sim/tb.sv
